### rtl/core/session_lru_table_macros.svh
// Assertion macros for the session table.
`ifndef SESSION_LRU_TABLE_MACROS_SVH
`define SESSION_LRU_TABLE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define SLT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("session_lru_table: same-cycle check failed");

// Next-cycle implication.
`define SLT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("session_lru_table: next-cycle check failed");

`else

`define SLT_ASSERT_NOW(label, ante, cons)
`define SLT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/core/slt_pkg.sv
package slt_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int CONTEXT_LIMIT = 32768;

  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int POS_W   = 16;
  localparam int STAMP_W = 64;

  typedef logic [IDX_W-1:0]   slt_idx_t;
  typedef logic [KEY_W-1:0]   slt_key_t;
  typedef logic [POS_W-1:0]   slt_pos_t;
  typedef logic [STAMP_W-1:0] slt_stamp_t;

  typedef struct packed {
    slt_key_t   key;
    slt_pos_t   position;
    slt_stamp_t stamp;
  } slt_entry_t;

  typedef struct packed {
    logic       re;
    slt_idx_t   raddr;
    logic       we;
    slt_idx_t   waddr;
    slt_entry_t wdata;
  } slt_ram_cmd_t;

  typedef enum logic {
    ACT_LOOKUP = 1'b0,
    ACT_STORE  = 1'b1
  } slt_action_t;

endpackage

### rtl/core/session_lru_table.sv
// Channel  Handshake              Payload
// -------  ---------------------  ----------------------------------------------
// in       in_valid / in_stall    action, client_id, token_position, restore_ok
// out      out_valid / out_stall  hit, start_position, evicted, evicted_id
//
// A request with a nonzero id scans the whole table: the entry RAM has one
// read port, so the scan for match, free slot and oldest stamp reads one
// entry per cycle; the finish state then writes back and loads the result.
// A request with id zero skips the scan and goes straight to the finish state.
// Synchronous reset clears the valid bits and the use counter; no sweep runs.
// A stalled result holds in the output register; a new request is taken
// meanwhile, and its write-back waits until the output register is free.
module session_lru_table
  import slt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [31:0] client_id,
  input  logic [15:0] token_position,
  input  logic        restore_ok,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [15:0] start_position,
  output logic        evicted,
  output logic [31:0] evicted_id
);

  `include "session_lru_table_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;

  logic [TABLE_ENTRIES-1:0] valid_bits;
  slt_stamp_t               use_counter;

  // latched request
  slt_action_t req_action;
  slt_key_t    req_id;
  slt_pos_t    req_pos;
  logic        req_rok;

  // scan bookkeeping
  logic [CNT_W-1:0] iss;
  logic             chk_vld;
  slt_idx_t         chk_idx;
  logic             found;
  slt_idx_t         found_idx;
  slt_pos_t         found_pos;
  logic             free_found;
  slt_idx_t         free_idx;
  logic             old_any;
  slt_idx_t         old_idx;
  slt_key_t         old_key;
  slt_stamp_t       old_stamp;

  slt_ram_cmd_t ram_cmd;
  slt_entry_t   rdata;

  logic       in_take;
  logic       out_free;
  logic       fin_go;
  logic       req_live;
  logic       do_store;
  logic       do_refresh;
  logic       do_evict;
  slt_pos_t   pos_sat;
  slt_idx_t   store_idx;
  slt_stamp_t stamp_next;

  slt_entry_ram u_ram (
    .clk   (clk),
    .cmd   (ram_cmd),
    .rdata (rdata)
  );

  assign in_stall   = (state != S_IDLE);
  assign in_take    = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign fin_go     = (state == S_FINISH) && out_free;
  assign pos_sat    = (req_pos > POS_W'(CONTEXT_LIMIT)) ? POS_W'(CONTEXT_LIMIT) : req_pos;
  assign stamp_next = use_counter + STAMP_W'(1);

  assign req_live   = (req_id != '0);
  assign do_store   = req_live && (req_action == ACT_STORE);
  assign do_refresh = req_live && (req_action == ACT_LOOKUP) && found && req_rok;
  assign do_evict   = do_store && !found && !free_found;

  always_comb begin
    priority if (found) begin
      store_idx = found_idx;
    end else if (free_found) begin
      store_idx = free_idx;
    end else begin
      store_idx = old_idx;
    end
  end

  always_comb begin
    ram_cmd       = '0;
    ram_cmd.re    = (state == S_SCAN) && (iss < CNT_W'(TABLE_ENTRIES));
    ram_cmd.raddr = iss[IDX_W-1:0];
    if (fin_go && do_store) begin
      ram_cmd.we             = 1'b1;
      ram_cmd.waddr          = store_idx;
      ram_cmd.wdata.key      = req_id;
      ram_cmd.wdata.position = pos_sat;
      ram_cmd.wdata.stamp    = stamp_next;
    end else if (fin_go && do_refresh) begin
      ram_cmd.we             = 1'b1;
      ram_cmd.waddr          = found_idx;
      ram_cmd.wdata.key      = req_id;
      ram_cmd.wdata.position = found_pos;
      ram_cmd.wdata.stamp    = stamp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      valid_bits  <= '0;
      use_counter <= '0;
      out_valid   <= 1'b0;
      chk_vld     <= 1'b0;
      iss         <= '0;
    end else begin
      if (out_valid && !out_stall && !fin_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            req_action <= slt_action_t'(action);
            req_id     <= client_id;
            req_pos    <= token_position;
            req_rok    <= restore_ok;
            iss        <= '0;
            chk_vld    <= 1'b0;
            found      <= 1'b0;
            free_found <= 1'b0;
            old_any    <= 1'b0;
            state      <= (client_id == '0) ? S_FINISH : S_SCAN;
          end
        end
        S_SCAN: begin
          chk_vld <= ram_cmd.re;
          chk_idx <= ram_cmd.raddr;
          if (ram_cmd.re) begin
            iss <= iss + CNT_W'(1);
          end
          if (chk_vld) begin
            if (valid_bits[chk_idx]) begin
              if (!found && (rdata.key == req_id)) begin
                found     <= 1'b1;
                found_idx <= chk_idx;
                found_pos <= rdata.position;
              end
              // strict compare keeps the lowest index on a tie
              if (!old_any || (rdata.stamp < old_stamp)) begin
                old_any   <= 1'b1;
                old_idx   <= chk_idx;
                old_key   <= rdata.key;
                old_stamp <= rdata.stamp;
              end
            end else if (!free_found) begin
              free_found <= 1'b1;
              free_idx   <= chk_idx;
            end
            if (chk_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            hit            <= req_live && found;
            start_position <= do_refresh ? found_pos : '0;
            evicted        <= do_evict;
            evicted_id     <= do_evict ? old_key : '0;
            if (do_store) begin
              valid_bits[store_idx] <= 1'b1;
            end
            if (do_store || do_refresh) begin
              use_counter <= stamp_next;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SLT_ASSERT_NOW(a_evict_is_miss, out_valid && evicted, !hit && (start_position == '0))
  `SLT_ASSERT_NOW(a_evict_when_full, out_valid && evicted, &valid_bits)
  `SLT_ASSERT_NEXT(a_write_bumps_stamp, ram_cmd.we, (use_counter == $past(stamp_next)) && (state == S_IDLE))

endmodule

### rtl/core/slt_entry_ram.sv
module slt_entry_ram
  import slt_pkg::*;
(
  input  logic         clk,
  input  slt_ram_cmd_t cmd,
  output slt_entry_t   rdata
);

  slt_entry_t mem [TABLE_ENTRIES];

  // Reads and writes never fall in the same cycle, so no bypass is needed.
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= cmd.wdata;
    end
    if (cmd.re) begin
      rdata <= mem[cmd.raddr];
    end
  end

endmodule

### dv/session_lru_table_tb.sv
module session_lru_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_SIZE   = 12;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN,
    STALL_HEAVY
  } stall_mode_t;

  typedef struct packed {
    slt_action_t action;
    slt_key_t    id;
    slt_pos_t    pos;
    logic        restore_ok;
  } session_req_t;

  typedef struct packed {
    logic     hit;
    slt_pos_t start_position;
    logic     evicted;
    slt_key_t evicted_id;
  } session_resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action = 1'b0;
  logic [31:0] client_id = '0;
  logic [15:0] token_position = '0;
  logic        restore_ok = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        hit;
  logic [15:0] start_position;
  logic        evicted;
  logic [31:0] evicted_id;

  // shadow copy of the table
  bit         shadow_valid [TABLE_ENTRIES];
  slt_key_t   shadow_key   [TABLE_ENTRIES];
  slt_pos_t   shadow_pos   [TABLE_ENTRIES];
  slt_stamp_t shadow_stamp [TABLE_ENTRIES];
  slt_stamp_t shadow_use_count = '0;

  session_resp_t pending_responses[$];

  int          cycle_count = 0;
  int          error_count = 0;
  int          request_count = 0;
  int          hit_count = 0;
  int          evict_count = 0;
  int          saturate_count = 0;
  int          stateless_count = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          holdoff_req = 0;
  int          hold_left = 0;
  bit          gaps_on = 1'b0;
  int          burst_left = 0;
  slt_key_t    id_pool [POOL_SIZE];

  session_lru_table dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .client_id     (client_id),
    .token_position(token_position),
    .restore_ok    (restore_ok),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit),
    .start_position(start_position),
    .evicted       (evicted),
    .evicted_id    (evicted_id)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, pending_responses.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic session_resp_t predict_table_access(session_req_t req);
    session_resp_t r;
    int slot;
    int oldest;
    slt_pos_t pos_sat;
    r = '0;
    slot = -1;
    if (req.id != '0) begin
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (slot < 0 && shadow_valid[i] && shadow_key[i] == req.id)
          slot = i;
      r.hit = (slot >= 0);
      if (req.action == ACT_LOOKUP) begin
        if (slot >= 0 && req.restore_ok) begin
          r.start_position = shadow_pos[slot];
          shadow_use_count = shadow_use_count + 1;
          shadow_stamp[slot] = shadow_use_count;
        end
      end else begin
        if (slot < 0) begin
          for (int i = 0; i < TABLE_ENTRIES; i++)
            if (slot < 0 && !shadow_valid[i])
              slot = i;
        end
        if (slot < 0) begin
          // lowest index wins among equal stamps
          oldest = 0;
          for (int i = 1; i < TABLE_ENTRIES; i++)
            if (shadow_stamp[i] < shadow_stamp[oldest])
              oldest = i;
          r.evicted = 1'b1;
          r.evicted_id = shadow_key[oldest];
          slot = oldest;
        end
        pos_sat = req.pos;
        if (req.pos > CONTEXT_LIMIT) begin
          pos_sat = slt_pos_t'(CONTEXT_LIMIT);
          saturate_count++;
        end
        shadow_valid[slot] = 1'b1;
        shadow_key[slot] = req.id;
        shadow_pos[slot] = pos_sat;
        shadow_use_count = shadow_use_count + 1;
        shadow_stamp[slot] = shadow_use_count;
      end
    end else begin
      stateless_count++;
    end
    if (r.hit)
      hit_count++;
    if (r.evicted)
      evict_count++;
    return r;
  endfunction

  // Call right after a rising edge; returns after the accepting edge, or after the pacing gap when gaps are on.
  task automatic send_request(slt_action_t act, slt_key_t id, slt_pos_t pos, logic rok);
    session_req_t req;
    req = '{action: act, id: id, pos: pos, restore_ok: rok};
    in_valid       <= 1'b1;
    action         <= act;
    client_id      <= id;
    token_position <= pos;
    restore_ok     <= rok;
    do @(posedge clk); while (in_stall);
    pending_responses.push_back(predict_table_access(req));
    request_count++;
    pace_sender();
  endtask

  task automatic pace_sender();
    int gap;
    if (!gaps_on)
      return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 7);
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_responses.size() != 0)
      @(posedge clk);
  endtask

  // receiver: long hold-off when asked, otherwise its own stall pattern
  always @(posedge clk) begin
    if (holdoff_req > 0) begin
      hold_left = holdoff_req;
      holdoff_req = 0;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:    out_stall <= 1'b0;
        STALL_RANDOM:  out_stall <= ($urandom_range(0, 2) == 0);
        STALL_PATTERN: out_stall <= ((cycle_count % 9) < 4);
        default:       out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    session_resp_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_responses.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result hit=%0b start=%0d evicted=%0b id=%h",
                 $time, hit, start_position, evicted, evicted_id);
      end else begin
        want = pending_responses.pop_front();
        if (hit !== want.hit) begin
          error_count++;
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
        end
        if (start_position !== want.start_position) begin
          error_count++;
          $display("%0t: start_position expected %0d actual %0d",
                   $time, want.start_position, start_position);
        end
        if (evicted !== want.evicted) begin
          error_count++;
          $display("%0t: evicted expected %0b actual %0b", $time, want.evicted, evicted);
        end
        if (evicted_id !== want.evicted_id) begin
          error_count++;
          $display("%0t: evicted_id expected %h actual %h",
                   $time, want.evicted_id, evicted_id);
        end
      end
    end
  end

  task automatic test_stateless_ids();
    send_request(ACT_LOOKUP, '0, 16'hFFFF, 1'b1);
    send_request(ACT_STORE, '0, 16'hFFFF, 1'b1);
  endtask

  task automatic test_hit_and_update();
    send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 16'h1234, 1'b1);
    send_request(ACT_STORE, 32'hFFFF_FFFF, 16'h0000, 1'b0);
    send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 1'b1);
    send_request(ACT_STORE, 32'hFFFF_FFFF, 16'h8000, 1'b1);
    send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 1'b1);
    // positions above the limit saturate
    send_request(ACT_STORE, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    send_request(ACT_STORE, 32'hFFFF_FFFF, 16'h8001, 1'b1);
    send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 16'h5555, 1'b1);
  endtask

  task automatic test_fill_and_evict();
    slt_key_t fill_ids [7];
    fill_ids = '{32'h0000_0001, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                 32'h0000_FFFF, 32'hFFFF_0000, 32'h1234_5678};
    foreach (fill_ids[i])
      send_request(ACT_STORE, fill_ids[i], slt_pos_t'(i * 4096 + 7), 1'b0);
    // refresh the oldest so the next one in line goes instead
    send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 16'h0, 1'b1);
    send_request(ACT_LOOKUP, 32'h0000_0001, 16'h0, 1'b0);
    send_request(ACT_STORE, 32'h0000_0002, 16'd100, 1'b0);
    send_request(ACT_STORE, 32'h0000_0003, 16'd200, 1'b1);
    send_request(ACT_LOOKUP, 32'h0000_0001, 16'h0, 1'b1);
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    holdoff_req = 400;
    for (int i = 0; i < 12; i++)
      send_request(ACT_STORE, id_pool[i % POOL_SIZE], slt_pos_t'($urandom()), 1'b1);
    drain_results();
  endtask

  task automatic test_random_sessions(int target, bit gaps, stall_mode_t mode);
    int issued;
    int pick;
    slt_key_t id;
    slt_pos_t pos;
    issued = 0;
    gaps_on = gaps;
    stall_mode = mode;
    foreach (id_pool[i]) begin
      id_pool[i] = $urandom();
      if (id_pool[i] == '0)
        id_pool[i] = 32'h0000_0001;
    end
    while (issued < target) begin
      pick = $urandom_range(0, 99);
      id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
      if ($urandom_range(0, 4) == 0)
        pos = slt_pos_t'($urandom_range(CONTEXT_LIMIT + 1, 65535));
      else
        pos = slt_pos_t'($urandom_range(0, CONTEXT_LIMIT));
      if (pick < 70) begin
        // normal session: look up, then save progress
        send_request(ACT_LOOKUP, id, slt_pos_t'($urandom()), $urandom_range(0, 6) != 0);
        send_request(ACT_STORE, id, pos, 1'($urandom_range(0, 1)));
        issued += 2;
      end else if (pick < 78) begin
        id = $urandom();
        send_request(ACT_STORE, id, slt_pos_t'($urandom()), 1'($urandom_range(0, 1)));
        if (id != '0)
          issued++;
      end else if (pick < 86) begin
        id = $urandom();
        send_request(ACT_LOOKUP, id, slt_pos_t'($urandom()), 1'($urandom_range(0, 1)));
        if (id != '0)
          issued++;
      end else if (pick < 91) begin
        send_request(slt_action_t'($urandom_range(0, 1)), '0,
                     slt_pos_t'($urandom()), 1'($urandom_range(0, 1)));
      end else begin
        // broken sequences: failed restores, then a repeat lookup or a store
        send_request(ACT_LOOKUP, id, slt_pos_t'($urandom()), 1'b0);
        send_request(slt_action_t'($urandom_range(0, 1)), id, pos,
                     1'($urandom_range(0, 1)));
        issued += 2;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gaps_on = 1'b1;
    stall_mode = STALL_RANDOM;
    test_stateless_ids();
    test_hit_and_update();
    test_fill_and_evict();
    drain_results();

    test_random_sessions(140, 1'b1, STALL_RANDOM);
    test_backpressure();
    test_random_sessions(130, 1'b0, STALL_NONE);
    test_random_sessions(130, 1'b1, STALL_PATTERN);
    test_random_sessions(130, 1'b0, STALL_HEAVY);

    drain_results();
    stall_mode = STALL_NONE;
    repeat (40) @(posedge clk);

    $display("Ran %0d requests: %0d hits, %0d evictions, %0d saturated stores, %0d stateless.",
             request_count, hit_count, evict_count, saturate_count, stateless_count);
    $display("Included a long output hold-off with the input backed up, %0d mismatches.",
             error_count);
    if (error_count == 0 && pending_responses.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
